FILE: design/ipv4hb_pkg.sv
`timescale 1ns / 1ps

package ipv4hb_pkg;

    localparam logic [7:0]  IP_VER_IHL   = 8'h45;
    localparam logic [15:0] HEADER_BYTES = 16'd20;
    localparam logic [15:0] MAX_PAYLOAD  = 16'd65515;
    localparam logic [15:0] BCAST_WORD   = 16'hffff;
    localparam logic [15:0] ZERO_WORD    = 16'h0000;

    localparam logic [7:0]  TOS_RESET    = 8'h10;
    localparam logic [7:0]  TTL_RESET    = 8'd128;
    localparam logic [31:0] SRC_RESET    = 32'h0000_0000;

    localparam int          CFG_IDX_W    = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVICE_TYPE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOP_LIMIT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_IP    = 2'd2;

    localparam int          SUM_W        = 19;

    localparam logic [3:0]  IDX_VER_TOS   = 4'd0;
    localparam logic [3:0]  IDX_TOTAL_LEN = 4'd1;
    localparam logic [3:0]  IDX_IDENT     = 4'd2;
    localparam logic [3:0]  IDX_FRAG      = 4'd3;
    localparam logic [3:0]  IDX_TTL_PROTO = 4'd4;
    localparam logic [3:0]  IDX_CSUM      = 4'd5;
    localparam logic [3:0]  IDX_SRC_HI    = 4'd6;
    localparam logic [3:0]  IDX_SRC_LO    = 4'd7;
    localparam logic [3:0]  IDX_DST_HI    = 4'd8;
    localparam logic [3:0]  IDX_DST_LO    = 4'd9;
    localparam logic [3:0]  IDX_LAST      = IDX_DST_LO;

    typedef struct packed {
        logic [15:0] payload_length;
        logic [7:0]  protocol;
    } in_t;

    typedef struct packed {
        logic [15:0] header_word;
        logic [3:0]  word_index;
        logic        last_word;
    } out_t;

    typedef struct packed {
        logic [7:0]  service_type;
        logic [7:0]  hop_limit;
        logic [31:0] source_ip;
    } cfg_t;

    typedef struct packed {
        logic [15:0]      ver_tos;
        logic [15:0]      total_len;
        logic [15:0]      ttl_proto;
        logic [15:0]      src_hi;
        logic [15:0]      src_lo;
        logic [SUM_W-1:0] sum;
    } hdr_t;

endpackage

FILE: design/ipv4_broadcast_header_builder_core.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Beat
// in        input      in_valid / in_stall   payload_length, protocol
// out       output     out_valid / out_stall header_word, word_index, last_word
// cfg       input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// Each request yields ten beats, one per cycle while out_stall is low, and holds the port
// until its last beat; the word serialiser is the limit, and the next request is taken
// meanwhile. A request passes the input, header, serialiser and output registers in turn.
// Reset is asynchronous and active low; configuration returns to 0x10, 128 and 0.0.0.0.
// A stall on the output holds the current beat and backs up through two request registers.
// Requests with a payload length above 65515 are taken and produce no beats.

module ipv4_broadcast_header_builder_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  ipv4hb_pkg::in_t                  in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output ipv4hb_pkg::out_t                 out_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ipv4hb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                      cfg_data
);
    import ipv4hb_pkg::*;

    cfg_t cfg;
    hdr_t hdr;
    logic hdr_valid;
    logic hdr_ready;

    assign cfg_ready = 1'b1;

    ipv4hb_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    ipv4hb_build u_build (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .hdr_valid (hdr_valid),
        .hdr_ready (hdr_ready),
        .hdr       (hdr)
    );

    ipv4hb_ser u_ser (
        .clk       (clk),
        .rst_n     (rst_n),
        .hdr_valid (hdr_valid),
        .hdr_ready (hdr_ready),
        .hdr       (hdr),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

FILE: design/ipv4hb_cfg.sv
`timescale 1ns / 1ps

module ipv4hb_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [ipv4hb_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [31:0]                    wr_data,
    output ipv4hb_pkg::cfg_t               cfg
);
    import ipv4hb_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                CFG_SERVICE_TYPE: cfg_next.service_type = wr_data[7:0];
                CFG_HOP_LIMIT:    cfg_next.hop_limit    = wr_data[7:0];
                CFG_SOURCE_IP:    cfg_next.source_ip    = wr_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.service_type <= TOS_RESET;
            cfg_reg.hop_limit    <= TTL_RESET;
            cfg_reg.source_ip    <= SRC_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: design/ipv4hb_build.sv
`timescale 1ns / 1ps

module ipv4hb_build (
    input  logic              clk,
    input  logic              rst_n,
    input  ipv4hb_pkg::cfg_t  cfg,
    input  logic              in_valid,
    output logic              in_stall,
    input  ipv4hb_pkg::in_t   in_data,
    output logic              hdr_valid,
    input  logic              hdr_ready,
    output ipv4hb_pkg::hdr_t  hdr
);
    import ipv4hb_pkg::*;

    logic  i_valid_reg;
    logic  i_valid_next;
    in_t   i_data_reg;
    logic  b_valid_reg;
    logic  b_valid_next;
    hdr_t  b_hdr_reg;
    hdr_t  b_hdr_next;
    logic  b_ready;
    logic  i_ready;
    logic  accept;
    logic  len_ok;

    // Requests whose total length would not fit in sixteen bits are taken and dropped.
    assign b_ready  = !b_valid_reg || hdr_ready;
    assign i_ready  = !i_valid_reg || b_ready;
    assign in_stall = !i_ready;
    assign accept   = in_valid && i_ready;
    assign len_ok   = in_data.payload_length <= MAX_PAYLOAD;

    always_comb
    begin
        i_valid_next = i_valid_reg;
        if (i_ready)
        begin
            i_valid_next = accept && len_ok;
        end
        b_valid_next = b_valid_reg;
        if (b_ready)
        begin
            b_valid_next = i_valid_reg;
        end
    end

    always_comb
    begin
        b_hdr_next.ver_tos   = {IP_VER_IHL, cfg.service_type};
        b_hdr_next.total_len = i_data_reg.payload_length + HEADER_BYTES;
        b_hdr_next.ttl_proto = {cfg.hop_limit, i_data_reg.protocol};
        b_hdr_next.src_hi    = cfg.source_ip[31:16];
        b_hdr_next.src_lo    = cfg.source_ip[15:0];
        b_hdr_next.sum       = SUM_W'(b_hdr_next.ver_tos) + SUM_W'(b_hdr_next.total_len)
                             + SUM_W'(b_hdr_next.ttl_proto) + SUM_W'(b_hdr_next.src_hi)
                             + SUM_W'(b_hdr_next.src_lo) + SUM_W'(BCAST_WORD)
                             + SUM_W'(BCAST_WORD);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            i_valid_reg <= i_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            i_data_reg <= in_data;
        end
        if (b_ready && i_valid_reg)
        begin
            b_hdr_reg <= b_hdr_next;
        end
    end

    assign hdr_valid = b_valid_reg;
    assign hdr       = b_hdr_reg;

endmodule

FILE: design/ipv4hb_ser.sv
`timescale 1ns / 1ps

module ipv4hb_ser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              hdr_valid,
    output logic              hdr_ready,
    input  ipv4hb_pkg::hdr_t  hdr,
    output logic              out_valid,
    input  logic              out_stall,
    output ipv4hb_pkg::out_t  out_data
);
    import ipv4hb_pkg::*;

    logic        act_reg;
    logic        act_next;
    logic [3:0]  idx_reg;
    logic [3:0]  idx_next;
    hdr_t        s_hdr_reg;
    logic [15:0] csum_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    out_t        out_reg;
    out_t        out_next;
    logic        adv;
    logic        emit;
    logic        done;
    logic        take;
    logic [16:0] fold1;
    logic [15:0] fold2;

    assign adv  = !out_valid_reg || !out_stall;
    assign emit = adv && act_reg;
    assign done = emit && (idx_reg == IDX_LAST);
    assign take = hdr_valid && (!act_reg || done);
    assign hdr_ready = !act_reg || done;

    // End-around carry: the second fold cannot carry again.
    assign fold1 = 17'(hdr.sum[15:0]) + 17'(hdr.sum[SUM_W-1:16]);
    assign fold2 = fold1[15:0] + 16'(fold1[16]);

    always_comb
    begin
        out_next.word_index = idx_reg;
        out_next.last_word  = (idx_reg == IDX_LAST);
        case (idx_reg)
            IDX_VER_TOS:   out_next.header_word = s_hdr_reg.ver_tos;
            IDX_TOTAL_LEN: out_next.header_word = s_hdr_reg.total_len;
            IDX_IDENT:     out_next.header_word = ZERO_WORD;
            IDX_FRAG:      out_next.header_word = ZERO_WORD;
            IDX_TTL_PROTO: out_next.header_word = s_hdr_reg.ttl_proto;
            IDX_CSUM:      out_next.header_word = csum_reg;
            IDX_SRC_HI:    out_next.header_word = s_hdr_reg.src_hi;
            IDX_SRC_LO:    out_next.header_word = s_hdr_reg.src_lo;
            IDX_DST_HI:    out_next.header_word = BCAST_WORD;
            IDX_DST_LO:    out_next.header_word = BCAST_WORD;
            default:       out_next.header_word = ZERO_WORD;
        endcase
    end

    always_comb
    begin
        act_next = act_reg;
        idx_next = idx_reg;
        if (emit)
        begin
            idx_next = done ? IDX_VER_TOS : idx_reg + 4'd1;
            act_next = !done;
        end
        if (take)
        begin
            act_next = 1'b1;
        end
        out_valid_next = out_valid_reg;
        if (adv)
        begin
            out_valid_next = act_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg       <= 1'b0;
            idx_reg       <= IDX_VER_TOS;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            act_reg       <= act_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s_hdr_reg <= hdr;
            csum_reg  <= ~fold2;
        end
        if (emit)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef ASSERT_OFF
    a_idle_index: assert property (@(posedge clk) disable iff (!rst_n)
        !act_reg |-> idx_reg == IDX_VER_TOS)
        else $error("serialiser idle with a nonzero word index");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_reg.word_index <= IDX_LAST)
        else $error("word index beyond the last header word");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_reg.last_word == (out_reg.word_index == IDX_LAST))
        else $error("last word flag disagrees with word index");

    a_next_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_stall && !out_reg.last_word
        |=> out_valid_reg && out_reg.word_index == $past(out_reg.word_index) + 4'd1)
        else $error("header words not delivered back to back in order");
`endif

endmodule
